// ===== hdl/dmpi_pkg.sv =====
// ============================================================================
// dmpi_pkg
// Shared widths, request and register codes and controller constants for the
// dual motor PI speed regulator.
// ============================================================================
package dmpi_pkg;

    // serial arithmetic unit widths
    localparam int MC_W   = 35;
    localparam int ML_W   = 20;
    localparam int PROD_W = MC_W + ML_W;
    localparam int DVS_W  = 20;
    localparam int ACC_W  = 42;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_KP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DLIM  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CPT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STALL = 3'd6;

    // request kinds
    localparam logic [2:0] REQ_TICK  = 3'd0;
    localparam logic [2:0] REQ_START = 3'd1;
    localparam logic [2:0] REQ_STOP  = 3'd2;
    localparam logic [2:0] REQ_DIR   = 3'd3;
    localparam logic [2:0] REQ_FAULT = 3'd4;

    // speed: sum * 30000 / (counts_per_turn * fill)
    localparam logic [14:0] SPEED_SCALE = 15'd30000;
    localparam logic signed [19:0] SPEED_MAX = 20'sd524287;
    localparam logic signed [19:0] SPEED_MIN = -20'sd524288;

    // P = kp*e*8192/125, dI = ki*tp*e*1024/15625
    localparam int P_SHIFT = 13;
    localparam int I_SHIFT = 10;
    localparam logic [DVS_W-1:0] P_DIV = 20'd125;
    localparam logic [DVS_W-1:0] I_DIV = 20'd15625;

    // stall detection
    localparam logic [14:0] STALL_TARGET_MIN       = 15'd300;
    localparam logic [11:0] STALL_DUTY_MIN         = 12'd300;
    localparam logic signed [19:0] STALL_SPEED_MAX = 20'sd50;

endpackage

// ===== hdl/dmpi_mul.sv =====
// ============================================================================
// dmpi_mul
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// ============================================================================
module dmpi_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [dmpi_pkg::MC_W-1:0]   i_mcand,
    input  logic [dmpi_pkg::ML_W-1:0]   i_mplier,
    output logic [dmpi_pkg::PROD_W-1:0] o_prod,
    output logic                        o_done
);
    localparam int CNT_W = $clog2(dmpi_pkg::ML_W);

    logic [dmpi_pkg::PROD_W-1:0] r_acc;
    logic [dmpi_pkg::PROD_W-1:0] r_mc;
    logic [dmpi_pkg::ML_W-1:0]   r_ml;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_busy;
    logic                        r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(dmpi_pkg::ML_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_mc  <= dmpi_pkg::PROD_W'(i_mcand);
            r_ml  <= i_mplier;
        end else if (r_busy) begin
            if (r_ml[0]) begin
                r_acc <= r_acc + r_mc;
            end
            r_mc <= r_mc << 1;
            r_ml <= r_ml >> 1;
        end
    end

    assign o_prod = r_acc;
    assign o_done = r_done;

endmodule

// ===== hdl/dmpi_div.sv =====
// ============================================================================
// dmpi_div
// Bit-serial restoring divider, one quotient bit per cycle, unsigned.
// ============================================================================
module dmpi_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [dmpi_pkg::PROD_W-1:0] i_dividend,
    input  logic [dmpi_pkg::DVS_W-1:0]  i_divisor,
    output logic [dmpi_pkg::PROD_W-1:0] o_quot,
    output logic                        o_done
);
    localparam int DVD_W = dmpi_pkg::PROD_W;
    localparam int DVS_W = dmpi_pkg::DVS_W;
    localparam int CNT_W = $clog2(DVD_W);

    logic [DVD_W-1:0] r_q;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DVS_W:0]   t_part;
    logic [DVS_W:0]   t_diff;
    logic             t_ge;

    always_comb begin
        t_part = {r_rem, r_q[DVD_W-1]};
        t_diff = t_part - {1'b0, r_dvs};
        t_ge   = t_part >= {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DVD_W-2:0], t_ge};
            r_rem <= t_ge ? t_diff[DVS_W-1:0] : t_part[DVS_W-1:0];
        end
    end

    assign o_quot = r_q;
    assign o_done = r_done;

endmodule

// ===== hdl/dual_motor_pi_speed_control_top.sv =====
// ============================================================================
// dual_motor_pi_speed_control_top
// Two-motor speed regulator: moving-average speed filter and PI loop with
// conditional anti-windup, stall and encoder fault handling.
// ============================================================================
// Usage:
//   Requests enter on i_valid/o_ready; one result leaves on o_valid/i_ready
//   for every request, in order. Registers are written through i_cfg_valid,
//   i_cfg_index, i_cfg_data; o_cfg_ready is always high, write only when idle.
//   One request is worked at a time. Start, stop, set direction and fault
//   requests go from ST_IDLE straight to ST_OUT, which loads the result
//   register. A tick runs on one shared bit-serial multiplier and one
//   bit-serial divider: the speed only while stopped, and the speed plus
//   one PI update per motor while running.
//   The result register decouples the sides: a new request transfer is taken
//   while a result still waits; the next result waits in place until the
//   receiver takes the previous one, holding o_ready low meanwhile.
//   Synchronous reset clears the control, filter, speed, duty and fault state,
//   loads the default gains and limits, and drops o_valid.
// ============================================================================
module dual_motor_pi_speed_control_top #(
    parameter int WINDOW_TAPS = 3
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [2:0]                          i_req_type,
    input  logic signed [31:0]                  i_enc_count_a,
    input  logic signed [31:0]                  i_enc_count_b,
    input  logic signed [15:0]                  i_target_a,
    input  logic signed [15:0]                  i_target_b,
    input  logic                                i_reverse_dir,
    input  logic [1:0]                          i_fault_bits,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [12:0]                  o_pwm_a,
    output logic signed [12:0]                  o_pwm_b,
    output logic signed [19:0]                  o_speed_a,
    output logic signed [19:0]                  o_speed_b,
    output logic                                o_running,
    output logic [1:0]                          o_fault_out,
    output logic                                o_reverse_now,
    output logic                                o_rejected,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dmpi_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dmpi_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    localparam int POS_W  = (WINDOW_TAPS > 1) ? $clog2(WINDOW_TAPS) : 1;
    localparam int FILL_W = $clog2(WINDOW_TAPS + 1);
    localparam int SUM_W  = 32 + $clog2(WINDOW_TAPS);
    localparam int MC_W   = dmpi_pkg::MC_W;
    localparam int ML_W   = dmpi_pkg::ML_W;
    localparam int PROD_W = dmpi_pkg::PROD_W;
    localparam int DVS_W  = dmpi_pkg::DVS_W;
    localparam int ACC_W  = dmpi_pkg::ACC_W;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_WIN,
        ST_DEN,
        ST_SPD_MUL,
        ST_SPD_PROD,
        ST_SPD_DIV,
        ST_PI_ERR,
        ST_PI_PMUL,
        ST_PI_PPROD,
        ST_PI_PDIV,
        ST_PI_KT,
        ST_PI_IPROD,
        ST_PI_IDIV,
        ST_PI_CAND,
        ST_PI_KEEP,
        ST_PI_DUTY,
        ST_FIN,
        ST_OUT
    } t_state;

    // configuration
    logic [10:0] r_kp;
    logic [12:0] r_ki;
    logic [11:0] r_dlim;
    logic [6:0]  r_tp;
    logic [14:0] r_cap;
    logic [15:0] r_cpt;
    logic [7:0]  r_sl;

    // controller state
    t_state                  r_state;
    logic [31:0]             r_win [2][WINDOW_TAPS];
    logic signed [SUM_W-1:0] r_sum [2];
    logic [31:0]             r_last [2];
    logic [31:0]             r_now [2];
    logic [POS_W-1:0]        r_pos;
    logic [FILL_W-1:0]       r_fill;
    logic [14:0]             r_tgt [2];
    logic signed [19:0]      r_spd [2];
    logic [11:0]             r_duty [2];
    logic [27:0]             r_int [2];
    logic [7:0]              r_sc [2];
    logic                    r_en;
    logic                    r_bwd;
    logic [1:0]              r_soft;
    logic [1:0]              r_hard;
    logic [1:0]              r_newf;
    logic                    r_m;
    logic                    r_rej;
    logic [DVS_W-1:0]        r_den;
    logic signed [20:0]      r_e;
    logic signed [ACC_W-1:0] r_p;
    logic signed [ACC_W-1:0] r_di;
    logic [27:0]             r_cand;

    // arithmetic unit operands
    logic [MC_W-1:0]   r_mc;
    logic [ML_W-1:0]   r_ml;
    logic [PROD_W-1:0] r_dvd;
    logic [DVS_W-1:0]  r_dvs;
    logic              r_mul_go;
    logic              r_div_go;
    logic [PROD_W-1:0] mul_prod;
    logic              mul_done;
    logic [PROD_W-1:0] div_q;
    logic              div_done;

    // result register
    logic               r_ovalid;
    logic signed [12:0] r_opwm_a;
    logic signed [12:0] r_opwm_b;
    logic signed [19:0] r_ospd_a;
    logic signed [19:0] r_ospd_b;
    logic               r_orun;
    logic [1:0]         r_ofault;
    logic               r_orev;
    logic               r_orej;

    // combinational helpers
    logic                    accept;
    logic [14:0]             ta_c;
    logic [14:0]             tb_c;
    logic                    tgt_zero;
    logic                    stop_req;
    logic                    restart_req;
    logic [31:0]             n_d [2];
    logic signed [SUM_W-1:0] n_sum [2];
    logic [FILL_W-1:0]       n_fill;
    logic [POS_W-1:0]        n_pos;
    logic [15:0]             cpt_nz;
    logic signed [SUM_W-1:0] s_sum;
    logic signed [SUM_W-1:0] s_sum_neg;
    logic [SUM_W-1:0]        sum_abs;
    logic signed [19:0]      spd_sat;
    logic signed [20:0]      e_calc;
    logic signed [20:0]      e_neg;
    logic [19:0]             e_abs;
    logic                    e_pos;
    logic signed [ACC_W-1:0] q_mag;
    logic signed [ACC_W-1:0] q_signed;
    logic [27:0]             lim_v;
    logic signed [ACC_W-1:0] lim_s;
    logic signed [ACC_W-1:0] cand_s;
    logic [27:0]             cand;
    logic signed [ACC_W-1:0] raw_s;
    logic                    keep;
    logic signed [ACC_W-1:0] out_s;
    logic [27:0]             out_c;
    logic [28:0]             rnd;
    logic [11:0]             n_duty;
    logic                    stall_cond;
    logic [7:0]              n_sc;
    logic                    stall_hit;
    logic [12:0]             duty_a_ext;
    logic [12:0]             duty_b_ext;

    dmpi_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_mul_go),
        .i_mcand  (r_mc),
        .i_mplier (r_ml),
        .o_prod   (mul_prod),
        .o_done   (mul_done)
    );

    dmpi_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (r_dvd),
        .i_divisor  (r_dvs),
        .o_quot     (div_q),
        .o_done     (div_done)
    );

    assign o_ready     = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && o_ready;

    always_comb begin
        ta_c = i_target_a[15] ? 15'd0 : ((i_target_a[14:0] > r_cap) ? r_cap : i_target_a[14:0]);
        tb_c = i_target_b[15] ? 15'd0 : ((i_target_b[14:0] > r_cap) ? r_cap : i_target_b[14:0]);
        tgt_zero = (ta_c == 15'd0) && (tb_c == 15'd0);

        stop_req = (accept && (((i_req_type == dmpi_pkg::REQ_START) &&
                                (tgt_zero || (r_hard != 2'd0))) ||
                               (i_req_type == dmpi_pkg::REQ_STOP) ||
                               ((i_req_type == dmpi_pkg::REQ_FAULT) && (i_fault_bits != 2'd0))))
                   || ((r_state == ST_FIN) && (r_newf != 2'd0));
        restart_req = accept && (i_req_type == dmpi_pkg::REQ_START) && !tgt_zero &&
                      (r_hard == 2'd0) && !r_en;

        for (int m = 0; m < 2; m++) begin
            n_d[m] = r_now[m] - r_last[m];
            if (r_bwd) begin
                n_d[m] = 32'd0 - n_d[m];
            end
            n_sum[m] = r_sum[m] - SUM_W'($signed(r_win[m][r_pos])) + SUM_W'($signed(n_d[m]));
        end
        n_fill = (r_fill < FILL_W'(WINDOW_TAPS)) ? r_fill + 1'b1 : r_fill;
        n_pos  = (r_pos == POS_W'(WINDOW_TAPS - 1)) ? '0 : r_pos + 1'b1;
        cpt_nz = (r_cpt == 16'd0) ? 16'd1 : r_cpt;

        s_sum     = r_sum[r_m];
        s_sum_neg = '0 - s_sum;
        sum_abs   = s_sum[SUM_W-1] ? s_sum_neg : s_sum;
        if (!s_sum[SUM_W-1]) begin
            spd_sat = (div_q > PROD_W'(524287)) ? dmpi_pkg::SPEED_MAX : $signed(div_q[19:0]);
        end else begin
            spd_sat = (div_q > PROD_W'(524288)) ? dmpi_pkg::SPEED_MIN
                                                : 20'sd0 - $signed(div_q[19:0]);
        end

        e_calc = $signed({6'b0, r_tgt[r_m]}) - 21'(r_spd[r_m]);
        e_neg  = 21'sd0 - r_e;
        e_abs  = r_e[20] ? e_neg[19:0] : r_e[19:0];
        e_pos  = !r_e[20] && (r_e != 21'sd0);

        q_mag    = $signed({1'b0, div_q[ACC_W-2:0]});
        q_signed = r_e[20] ? -q_mag : q_mag;

        lim_v  = {r_dlim, 16'b0};
        lim_s  = $signed(ACC_W'(lim_v));
        cand_s = $signed(ACC_W'(r_int[r_m])) + r_di;
        if (cand_s < 0) begin
            cand = 28'd0;
        end else if (cand_s > lim_s) begin
            cand = lim_v;
        end else begin
            cand = cand_s[27:0];
        end

        raw_s = r_p + $signed(ACC_W'(r_cand));
        keep  = ((raw_s >= 0) && (raw_s <= lim_s)) || ((raw_s > lim_s) && r_e[20]) ||
                ((raw_s < 0) && e_pos);

        out_s = r_p + $signed(ACC_W'(r_int[r_m]));
        if (out_s < 0) begin
            out_c = 28'd0;
        end else if (out_s > lim_s) begin
            out_c = lim_v;
        end else begin
            out_c = out_s[27:0];
        end
        rnd    = {1'b0, out_c} + 29'd32768;
        n_duty = rnd[27:16];

        stall_cond = (r_tgt[r_m] >= dmpi_pkg::STALL_TARGET_MIN) &&
                     (n_duty >= dmpi_pkg::STALL_DUTY_MIN) &&
                     (r_spd[r_m] <= dmpi_pkg::STALL_SPEED_MAX);
        n_sc      = (r_sc[r_m] < r_sl) ? r_sc[r_m] + 8'd1 : r_sc[r_m];
        stall_hit = (n_sc >= r_sl);

        duty_a_ext = {1'b0, r_duty[0]};
        duty_b_ext = {1'b0, r_duty[1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp   <= 11'd200;
            r_ki   <= 13'd1600;
            r_dlim <= 12'd1000;
            r_tp   <= 7'd5;
            r_cap  <= 15'd3000;
            r_cpt  <= 16'd1560;
            r_sl   <= 8'd100;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                dmpi_pkg::CFG_KP:    r_kp   <= i_cfg_data[10:0];
                dmpi_pkg::CFG_KI:    r_ki   <= i_cfg_data[12:0];
                dmpi_pkg::CFG_DLIM:  r_dlim <= i_cfg_data[11:0];
                dmpi_pkg::CFG_TICK:  r_tp   <= i_cfg_data[6:0];
                dmpi_pkg::CFG_CAP:   r_cap  <= i_cfg_data[14:0];
                dmpi_pkg::CFG_CPT:   r_cpt  <= i_cfg_data;
                dmpi_pkg::CFG_STALL: r_sl   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_en     <= 1'b0;
            r_bwd    <= 1'b0;
            r_soft   <= 2'd0;
            r_hard   <= 2'd0;
            r_newf   <= 2'd0;
            r_m      <= 1'b0;
            r_rej    <= 1'b0;
            r_pos    <= '0;
            r_fill   <= '0;
            r_mul_go <= 1'b0;
            r_div_go <= 1'b0;
            r_ovalid <= 1'b0;
            for (int m = 0; m < 2; m++) begin
                r_sum[m]  <= '0;
                r_last[m] <= '0;
                r_tgt[m]  <= '0;
                r_spd[m]  <= '0;
                r_duty[m] <= '0;
                r_int[m]  <= '0;
                r_sc[m]   <= '0;
                for (int t = 0; t < WINDOW_TAPS; t++) begin
                    r_win[m][t] <= '0;
                end
            end
        end else begin
            r_mul_go <= 1'b0;
            r_div_go <= 1'b0;
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_rej   <= 1'b0;
                        r_state <= ST_OUT;
                        unique case (i_req_type)
                            dmpi_pkg::REQ_TICK: begin
                                r_now[0] <= i_enc_count_a;
                                r_now[1] <= i_enc_count_b;
                                r_newf   <= 2'd0;
                                r_state  <= ST_WIN;
                            end
                            dmpi_pkg::REQ_START: begin
                                if (!tgt_zero && (r_hard != 2'd0)) begin
                                    r_soft <= r_hard;
                                end else if (!tgt_zero) begin
                                    r_soft   <= 2'd0;
                                    r_tgt[0] <= ta_c;
                                    r_tgt[1] <= tb_c;
                                    r_en     <= 1'b1;
                                end
                            end
                            dmpi_pkg::REQ_DIR: begin
                                if (r_en) begin
                                    r_rej <= 1'b1;
                                end else begin
                                    r_bwd <= i_reverse_dir;
                                end
                            end
                            dmpi_pkg::REQ_FAULT: begin
                                r_hard <= r_hard | i_fault_bits;
                                r_soft <= r_soft | i_fault_bits;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_WIN: begin
                    for (int m = 0; m < 2; m++) begin
                        r_last[m]       <= r_now[m];
                        r_win[m][r_pos] <= n_d[m];
                        r_sum[m]        <= n_sum[m];
                    end
                    r_fill   <= n_fill;
                    r_pos    <= n_pos;
                    r_mc     <= MC_W'(cpt_nz);
                    r_ml     <= ML_W'(n_fill);
                    r_mul_go <= 1'b1;
                    r_state  <= ST_DEN;
                end
                ST_DEN: begin
                    if (mul_done) begin
                        r_den   <= mul_prod[DVS_W-1:0];
                        r_m     <= 1'b0;
                        r_state <= ST_SPD_MUL;
                    end
                end
                ST_SPD_MUL: begin
                    r_mc     <= MC_W'(sum_abs);
                    r_ml     <= ML_W'(dmpi_pkg::SPEED_SCALE);
                    r_mul_go <= 1'b1;
                    r_state  <= ST_SPD_PROD;
                end
                ST_SPD_PROD: begin
                    if (mul_done) begin
                        r_dvd    <= mul_prod;
                        r_dvs    <= r_den;
                        r_div_go <= 1'b1;
                        r_state  <= ST_SPD_DIV;
                    end
                end
                ST_SPD_DIV: begin
                    if (div_done) begin
                        r_spd[r_m] <= spd_sat;
                        if (!r_m) begin
                            r_m     <= 1'b1;
                            r_state <= ST_SPD_MUL;
                        end else if (r_en) begin
                            r_m     <= 1'b0;
                            r_state <= ST_PI_ERR;
                        end else begin
                            r_state <= ST_OUT;
                        end
                    end
                end
                ST_PI_ERR: begin
                    if (r_tgt[r_m] == 15'd0) begin
                        r_int[r_m]  <= '0;
                        r_duty[r_m] <= '0;
                        if (r_m) begin
                            r_state <= ST_FIN;
                        end else begin
                            r_m <= 1'b1;
                        end
                    end else begin
                        r_e     <= e_calc;
                        r_state <= ST_PI_PMUL;
                    end
                end
                ST_PI_PMUL: begin
                    r_mc     <= MC_W'(r_kp);
                    r_ml     <= e_abs;
                    r_mul_go <= 1'b1;
                    r_state  <= ST_PI_PPROD;
                end
                ST_PI_PPROD: begin
                    if (mul_done) begin
                        r_dvd    <= mul_prod << dmpi_pkg::P_SHIFT;
                        r_dvs    <= dmpi_pkg::P_DIV;
                        r_div_go <= 1'b1;
                        r_state  <= ST_PI_PDIV;
                    end
                end
                ST_PI_PDIV: begin
                    if (div_done) begin
                        r_p      <= q_signed;
                        r_mc     <= MC_W'(r_ki);
                        r_ml     <= ML_W'(r_tp);
                        r_mul_go <= 1'b1;
                        r_state  <= ST_PI_KT;
                    end
                end
                ST_PI_KT: begin
                    if (mul_done) begin
                        r_mc     <= MC_W'(mul_prod[ML_W-1:0]);
                        r_ml     <= e_abs;
                        r_mul_go <= 1'b1;
                        r_state  <= ST_PI_IPROD;
                    end
                end
                ST_PI_IPROD: begin
                    if (mul_done) begin
                        r_dvd    <= mul_prod << dmpi_pkg::I_SHIFT;
                        r_dvs    <= dmpi_pkg::I_DIV;
                        r_div_go <= 1'b1;
                        r_state  <= ST_PI_IDIV;
                    end
                end
                ST_PI_IDIV: begin
                    if (div_done) begin
                        r_di    <= q_signed;
                        r_state <= ST_PI_CAND;
                    end
                end
                ST_PI_CAND: begin
                    r_cand  <= cand;
                    r_state <= ST_PI_KEEP;
                end
                ST_PI_KEEP: begin
                    if (keep) begin
                        r_int[r_m] <= r_cand;
                    end
                    r_state <= ST_PI_DUTY;
                end
                ST_PI_DUTY: begin
                    r_duty[r_m] <= n_duty;
                    if (stall_cond) begin
                        r_sc[r_m] <= n_sc;
                        if (stall_hit) begin
                            r_newf[r_m] <= 1'b1;
                        end
                    end else begin
                        r_sc[r_m] <= 8'd0;
                    end
                    if (r_m) begin
                        r_state <= ST_FIN;
                    end else begin
                        r_m     <= 1'b1;
                        r_state <= ST_PI_ERR;
                    end
                end
                ST_FIN: begin
                    r_soft  <= r_soft | r_newf;
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (!r_ovalid || i_ready) begin
                        r_ovalid <= 1'b1;
                        r_opwm_a <= r_bwd ? $signed(13'd0 - duty_a_ext) : $signed(duty_a_ext);
                        r_opwm_b <= r_bwd ? $signed(13'd0 - duty_b_ext) : $signed(duty_b_ext);
                        r_ospd_a <= r_spd[0];
                        r_ospd_b <= r_spd[1];
                        r_orun   <= r_en;
                        r_ofault <= r_soft;
                        r_orev   <= r_bwd;
                        r_orej   <= r_rej;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase

            if (restart_req) begin
                r_pos  <= '0;
                r_fill <= '0;
                r_last[0] <= i_enc_count_a;
                r_last[1] <= i_enc_count_b;
                for (int m = 0; m < 2; m++) begin
                    r_sum[m]  <= '0;
                    r_spd[m]  <= '0;
                    r_duty[m] <= '0;
                    r_int[m]  <= '0;
                    r_sc[m]   <= '0;
                    for (int t = 0; t < WINDOW_TAPS; t++) begin
                        r_win[m][t] <= '0;
                    end
                end
            end

            if (stop_req) begin
                r_en  <= 1'b0;
                r_bwd <= 1'b0;
                for (int m = 0; m < 2; m++) begin
                    r_tgt[m]  <= '0;
                    r_int[m]  <= '0;
                    r_duty[m] <= '0;
                end
            end
        end
    end

    assign o_valid       = r_ovalid;
    assign o_pwm_a       = r_opwm_a;
    assign o_pwm_b       = r_opwm_b;
    assign o_speed_a     = r_ospd_a;
    assign o_speed_b     = r_ospd_b;
    assign o_running     = r_orun;
    assign o_fault_out   = r_ofault;
    assign o_reverse_now = r_orev;
    assign o_rejected    = r_orej;

endmodule

// ===== hdl/dmpi_checker.sv =====
// ============================================================================
// dmpi_checker
// Port-level checks of the dual motor regulator, bound to the top level.
// ============================================================================
module dmpi_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_ready,
    input logic                            o_valid,
    input logic                            i_ready,
    input logic signed [12:0]              o_pwm_a,
    input logic signed [12:0]              o_pwm_b,
    input logic                            o_running,
    input logic [1:0]                      o_fault_out,
    input logic                            o_rejected
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pwm_a) && $stable(o_pwm_b))
        else $error("result changed while stalled");

    // one request in flight
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("request taken while busy");

    a_reject_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rejected |-> o_running)
        else $error("direction refused while stopped");

    a_idle_no_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_running |-> (o_pwm_a == 13'sd0) && (o_pwm_b == 13'sd0))
        else $error("drive while stopped");

    a_run_no_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_running |-> (o_fault_out == 2'd0))
        else $error("running with fault reported");

endmodule

bind dual_motor_pi_speed_control_top dmpi_checker u_dmpi_checker (.*);

// ===== test/tb_top.sv =====
// ============================================================================
// tb_top
// Self-checking bench for the dual motor PI speed regulator. A scoreboard
// class predicts every result from the accepted requests and register writes,
// and compares the results in order, field by field. Requests come in bursts
// with random gaps. The result side stalls at random, with one long hold-off
// that fills the block. The bench covers several register settings, extremes
// among them, and ends with the encoder fault requests, which latch for good.
// ============================================================================
`timescale 1ns / 1ps

module tb_top;

    localparam int  TAPS      = 3;
    localparam int  HOLD_LEN  = 3000;
    localparam longint LIMIT  = 12000000;

    typedef struct {
        logic [2:0]         kind;
        logic signed [31:0] cnt_a;
        logic signed [31:0] cnt_b;
        logic signed [15:0] tgt_a;
        logic signed [15:0] tgt_b;
        logic               rev;
        logic [1:0]         fbits;
    } request_t;

    typedef struct {
        logic signed [12:0] pwm_a;
        logic signed [12:0] pwm_b;
        logic signed [19:0] speed_a;
        logic signed [19:0] speed_b;
        logic               running;
        logic [1:0]         fault;
        logic               rev;
        logic               rejected;
    } status_t;

    class regulator_scoreboard;
        int kp, ki, dlim, tick_ms, cap, cpt, stall_lim;
        bit en, bwd;
        bit [1:0] soft_mask, hard;
        longint tgt[2], spd[2], duty[2], integ[2], wsum[2];
        longint win[2][TAPS];
        bit [31:0] last[2];
        int pos, fill;
        int stall_cnt[2];
        status_t pending[$];
        int errors, checked, ticks, starts;

        function new();
            kp = 200; ki = 1600; dlim = 1000; tick_ms = 5;
            cap = 3000; cpt = 1560; stall_lim = 100;
            en = 0; bwd = 0; soft_mask = 0; hard = 0;
            tgt[0] = 0; tgt[1] = 0;
            restart(0, 0);
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        function void halt();
            en = 0; bwd = 0;
            for (int m = 0; m < 2; m++) begin
                tgt[m] = 0; integ[m] = 0; duty[m] = 0;
            end
        endfunction

        function void restart(bit [31:0] ca, bit [31:0] cb);
            last[0] = ca; last[1] = cb;
            pos = 0; fill = 0;
            for (int m = 0; m < 2; m++) begin
                for (int k = 0; k < TAPS; k++) win[m][k] = 0;
                wsum[m] = 0; spd[m] = 0; duty[m] = 0; integ[m] = 0; stall_cnt[m] = 0;
            end
        endfunction

        function void write_reg(logic [dmpi_pkg::CFG_IDX_W-1:0] idx,
                                logic [dmpi_pkg::CFG_DATA_W-1:0] v);
            case (idx)
                dmpi_pkg::CFG_KP:    kp = v[10:0];
                dmpi_pkg::CFG_KI:    ki = v[12:0];
                dmpi_pkg::CFG_DLIM:  dlim = v[11:0];
                dmpi_pkg::CFG_TICK:  tick_ms = v[6:0];
                dmpi_pkg::CFG_CAP:   cap = v[14:0];
                dmpi_pkg::CFG_CPT:   cpt = v[15:0];
                dmpi_pkg::CFG_STALL: stall_lim = v[7:0];
                default: ;
            endcase
        endfunction

        function void tick(bit [31:0] ca, bit [31:0] cb);
            bit [31:0] now[2];
            bit [31:0] d;
            longint den, e, p, di, cand, raw, lim;
            logic signed [95:0] wide;
            bit [1:0] nf;
            now[0] = ca; now[1] = cb; nf = 0;
            for (int m = 0; m < 2; m++) begin
                d = now[m] - last[m];
                if (bwd) d = 32'd0 - d;
                last[m] = now[m];
                wsum[m] -= win[m][pos];
                win[m][pos] = longint'(signed'(d));
                wsum[m] += win[m][pos];
            end
            if (fill < TAPS) fill++;
            pos = (pos + 1) % TAPS;
            den = longint'(cpt == 0 ? 1 : cpt) * fill;
            for (int m = 0; m < 2; m++)
                spd[m] = clamp((wsum[m] * 30000) / den, -524288, 524287);
            if (!en) return;
            lim = longint'(dlim) * 65536;
            for (int m = 0; m < 2; m++) begin
                if (tgt[m] == 0) begin
                    integ[m] = 0; duty[m] = 0;
                    continue;
                end
                e = tgt[m] - spd[m];
                p = (longint'(kp) * e * 65536) / 1000;
                wide = ki;
                wide = wide * e;
                wide = wide * tick_ms;
                wide = wide * 65536;
                wide = wide / 1000000;
                di = longint'(wide);
                cand = clamp(integ[m] + di, 0, lim);
                raw = p + cand;
                if ((raw >= 0 && raw <= lim) || (raw > lim && e < 0) || (raw < 0 && e > 0))
                    integ[m] = cand;
                raw = clamp(p + integ[m], 0, lim);
                duty[m] = (raw + 32768) >>> 16;
                if (tgt[m] >= 300 && duty[m] >= 300 && spd[m] <= 50) begin
                    if (stall_cnt[m] < stall_lim) stall_cnt[m]++;
                    if (stall_cnt[m] >= stall_lim) nf[m] = 1'b1;
                end else begin
                    stall_cnt[m] = 0;
                end
            end
            if (nf != 0) begin
                soft_mask |= nf;
                halt();
            end
        endfunction

        function void note_request(request_t r);
            status_t s;
            longint ta, tb;
            bit rej;
            rej = 0;
            case (r.kind)
                dmpi_pkg::REQ_TICK: begin
                    ticks++;
                    tick(r.cnt_a, r.cnt_b);
                end
                dmpi_pkg::REQ_START: begin
                    starts++;
                    ta = clamp(r.tgt_a, 0, cap);
                    tb = clamp(r.tgt_b, 0, cap);
                    if (ta == 0 && tb == 0) begin
                        halt();
                    end else if (hard != 0) begin
                        soft_mask = hard;
                        halt();
                    end else begin
                        if (!en) restart(r.cnt_a, r.cnt_b);
                        soft_mask = 0;
                        tgt[0] = ta; tgt[1] = tb;
                        en = 1;
                    end
                end
                dmpi_pkg::REQ_STOP: halt();
                dmpi_pkg::REQ_DIR: begin
                    if (en) rej = 1;
                    else bwd = r.rev;
                end
                dmpi_pkg::REQ_FAULT: begin
                    if (r.fbits != 0) begin
                        hard |= r.fbits;
                        soft_mask |= r.fbits;
                        halt();
                    end
                end
                default: ;
            endcase
            s.pwm_a    = 13'(bwd ? -duty[0] : duty[0]);
            s.pwm_b    = 13'(bwd ? -duty[1] : duty[1]);
            s.speed_a  = 20'(spd[0]);
            s.speed_b  = 20'(spd[1]);
            s.running  = en;
            s.fault    = soft_mask;
            s.rev      = bwd;
            s.rejected = rej;
            pending.push_back(s);
        endfunction

        task report(string what, longint got, longint want);
            errors++;
            $display("mismatch at result %0d: %s got %0d expected %0d",
                     checked, what, got, want);
        endtask

        task check_result(status_t s);
            status_t x;
            if (pending.size() == 0) begin
                report("unexpected result, valid", 1, 0);
                return;
            end
            x = pending.pop_front();
            if (s.pwm_a !== x.pwm_a)       report("pwm_a", s.pwm_a, x.pwm_a);
            if (s.pwm_b !== x.pwm_b)       report("pwm_b", s.pwm_b, x.pwm_b);
            if (s.speed_a !== x.speed_a)   report("speed_a", s.speed_a, x.speed_a);
            if (s.speed_b !== x.speed_b)   report("speed_b", s.speed_b, x.speed_b);
            if (s.running !== x.running)   report("running", s.running, x.running);
            if (s.fault !== x.fault)       report("fault_out", s.fault, x.fault);
            if (s.rev !== x.rev)           report("reverse_now", s.rev, x.rev);
            if (s.rejected !== x.rejected) report("rejected", s.rejected, x.rejected);
            checked++;
        endtask
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic o_ready;
    logic [2:0] i_req_type = '0;
    logic signed [31:0] i_enc_count_a = '0;
    logic signed [31:0] i_enc_count_b = '0;
    logic signed [15:0] i_target_a = '0;
    logic signed [15:0] i_target_b = '0;
    logic i_reverse_dir = 0;
    logic [1:0] i_fault_bits = '0;
    logic o_valid;
    logic i_ready = 0;
    logic signed [12:0] o_pwm_a, o_pwm_b;
    logic signed [19:0] o_speed_a, o_speed_b;
    logic o_running, o_reverse_now, o_rejected;
    logic [1:0] o_fault_out;
    logic i_cfg_valid = 0;
    logic o_cfg_ready;
    logic [dmpi_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [dmpi_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    regulator_scoreboard sb = new();
    longint cycles = 0;
    bit hold_req = 0;
    int hold_left = 0;
    int stall_pct = 0;
    int burst_left = 0;
    int sent = 0;
    int settings = 1;
    bit [31:0] pos_a = 0, pos_b = 0;

    dual_motor_pi_speed_control_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_req_type(i_req_type), .i_enc_count_a(i_enc_count_a),
        .i_enc_count_b(i_enc_count_b), .i_target_a(i_target_a),
        .i_target_b(i_target_b), .i_reverse_dir(i_reverse_dir),
        .i_fault_bits(i_fault_bits),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_pwm_a(o_pwm_a), .o_pwm_b(o_pwm_b),
        .o_speed_a(o_speed_a), .o_speed_b(o_speed_b),
        .o_running(o_running), .o_fault_out(o_fault_out),
        .o_reverse_now(o_reverse_now), .o_rejected(o_rejected),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // result side: check each transfer, then pick the next ready value
    always @(posedge i_clk) begin
        status_t s;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                s.pwm_a = o_pwm_a;     s.pwm_b = o_pwm_b;
                s.speed_a = o_speed_a; s.speed_b = o_speed_b;
                s.running = o_running; s.fault = o_fault_out;
                s.rev = o_reverse_now; s.rejected = o_rejected;
                sb.check_result(s);
            end
            if (cycles % 256 == 0)
                case ($urandom_range(3))
                    0, 1: stall_pct = 0;
                    2: stall_pct = 30;
                    default: stall_pct = 75;
                endcase
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 0;
                hold_left = HOLD_LEN;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task send(logic [2:0] kind, logic [31:0] ca, logic [31:0] cb,
              logic [15:0] ta, logic [15:0] tb, logic rev, logic [1:0] fb);
        request_t r;
        r.kind = kind; r.cnt_a = ca; r.cnt_b = cb;
        r.tgt_a = ta; r.tgt_b = tb; r.rev = rev; r.fbits = fb;
        i_valid <= 1'b1;
        i_req_type <= kind;
        i_enc_count_a <= ca;
        i_enc_count_b <= cb;
        i_target_a <= ta;
        i_target_b <= tb;
        i_reverse_dir <= rev;
        i_fault_bits <= fb;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_request(r);
        sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 20);
        end
    endtask

    task tick_by(int da, int db);
        pos_a += da;
        pos_b += db;
        send(dmpi_pkg::REQ_TICK, pos_a, pos_b, $urandom, $urandom, $urandom, $urandom);
    endtask

    task drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task write_all(int kp, int ki, int dl, int tp, int cp, int cpt, int st);
        int vals[7];
        vals = '{kp, ki, dl, tp, cp, cpt, st};
        drain();
        for (int k = 0; k < 7; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= dmpi_pkg::CFG_IDX_W'(k);
            i_cfg_data <= dmpi_pkg::CFG_DATA_W'(vals[k]);
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            sb.write_reg(dmpi_pkg::CFG_IDX_W'(k), dmpi_pkg::CFG_DATA_W'(vals[k]));
        end
        i_cfg_valid <= 1'b0;
        settings++;
    endtask

    function int pick_delta(int mode);
        case (mode)
            0: return $urandom_range(0, 4) - 2;
            1: return $urandom_range(0, 600) - 100;
            2: return $urandom_range(0, 40000) - 20000;
            default: return $urandom;
        endcase
    endfunction

    function logic [15:0] pick_target();
        int c;
        c = (sb.cap == 0) ? 1 : sb.cap;
        case ($urandom_range(9))
            0: return 16'd0;
            1: return 16'($urandom);
            2: return 16'($urandom_range(0, 2000)) - 16'd1000;
            default: return 16'($urandom_range(1, c + c / 8));
        endcase
    endfunction

    task random_items(int n, bit faults);
        int goal, k, mode;
        logic [2:0] kind;
        goal = sent + n;
        while (sent < goal) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5, 6: begin
                    if ($urandom_range(3) == 0) begin
                        pos_a = $urandom; pos_b = $urandom;
                    end
                    send(dmpi_pkg::REQ_START, pos_a, pos_b, pick_target(), pick_target(),
                         $urandom, $urandom);
                    mode = ($urandom_range(9) < 2) ? 0 :
                           ($urandom_range(9) < 8) ? 1 : $urandom_range(2, 3);
                    k = $urandom_range(3, 25);
                    for (int i = 0; i < k; i++) begin
                        if ($urandom_range(29) == 0)
                            send(dmpi_pkg::REQ_DIR, $urandom, $urandom, $urandom, $urandom,
                                 $urandom, $urandom);
                        else if (faults && $urandom_range(39) == 0)
                            send(dmpi_pkg::REQ_FAULT, $urandom, $urandom, $urandom, $urandom,
                                 $urandom, $urandom);
                        else
                            tick_by(pick_delta(mode), pick_delta(mode));
                    end
                    if ($urandom_range(9) < 7)
                        send(dmpi_pkg::REQ_STOP, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom);
                end
                7: send(dmpi_pkg::REQ_DIR, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom);
                8: begin
                    kind = 3'($urandom_range(7));
                    send(kind, $urandom, $urandom, $urandom, $urandom, $urandom,
                         (kind == dmpi_pkg::REQ_FAULT && !faults) ? 2'b00 : 2'($urandom));
                end
                default: begin
                    k = $urandom_range(1, 6);
                    for (int i = 0; i < k; i++) tick_by(pick_delta(1), pick_delta(2));
                end
            endcase
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: direction, clamps, zero target, wrap, refused direction
        send(dmpi_pkg::REQ_DIR, 0, 0, 0, 0, 1'b1, 2'b00);
        send(dmpi_pkg::REQ_DIR, 0, 0, 0, 0, 1'b0, 2'b00);
        send(dmpi_pkg::REQ_START, 0, 0, 16'sh7fff, 16'sh8000, 1'b0, 2'b00);
        repeat (4) tick_by(0, 0);
        send(dmpi_pkg::REQ_DIR, 0, 0, 0, 0, 1'b1, 2'b00);
        pos_a = 32'h7fffffff; pos_b = 32'h80000000;
        tick_by(0, 0);
        tick_by(1, -1);
        for (int k = 5; k < 8; k++) send(3'(k), $urandom, $urandom, $urandom, $urandom, 1, 3);
        send(dmpi_pkg::REQ_START, 0, 0, 16'sd0, -16'sd5, 1'b0, 2'b00);
        send(dmpi_pkg::REQ_FAULT, 0, 0, 0, 0, 1'b0, 2'b00);
        send(dmpi_pkg::REQ_DIR, 0, 0, 0, 0, 1'b1, 2'b00);
        pos_a = 0; pos_b = 0;
        send(dmpi_pkg::REQ_START, 0, 0, 16'sd1000, 16'sd2000, 1'b0, 2'b00);
        repeat (3) tick_by(-60, -150);
        send(dmpi_pkg::REQ_STOP, 0, 0, 0, 0, 1'b0, 2'b00);

        random_items(200, 0);
        hold_req = 1;
        random_items(150, 0);
        write_all(2000, 5000, 4095, 100, 32767, 65535, 255);
        random_items(300, 0);
        write_all(0, 0, 1, 1, 0, 0, 0);
        random_items(120, 0);
        write_all(800, 3000, 300, 10, 3000, 100, 1);
        random_items(150, 0);
        write_all($urandom_range(2000), $urandom_range(5000), $urandom_range(1, 4095),
                  $urandom_range(1, 100), $urandom_range(32767),
                  $urandom_range(1, 65535), $urandom_range(255));
        random_items(300, 0);
        write_all(200, 1600, 1000, 5, 3000, 1560, 100);
        random_items(200, 0);

        // encoder faults latch: kept for the end of the run
        send(dmpi_pkg::REQ_FAULT, 0, 0, 0, 0, 1'b0, 2'b01);
        send(dmpi_pkg::REQ_START, 0, 0, 16'sd1000, 16'sd1000, 1'b0, 2'b00);
        send(dmpi_pkg::REQ_FAULT, 0, 0, 0, 0, 1'b0, 2'b10);
        send(dmpi_pkg::REQ_FAULT, 0, 0, 0, 0, 1'b0, 2'b11);
        random_items(120, 1);

        drain();
        $display("covered %0d requests: %0d ticks, %0d starts, %0d register settings",
                 sent, sb.ticks, sb.starts, settings);
        $display("%0d results checked, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
